// File: rtl/tlgr_pkg.sv
// Shared types, constants and font table of the text line glyph renderer.
package tlgr_pkg;

    localparam int LINE_COLUMNS = 128;
    localparam int GLYPH_WIDTH  = 5;
    localparam int CELL_WIDTH   = GLYPH_WIDTH + 1;
    localparam int LAST_FIT     = LINE_COLUMNS - CELL_WIDTH;
    localparam int GLYPH_COUNT  = 41;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
    localparam logic [7:0] COL_LOW_CMD   = 8'h00;
    localparam logic [7:0] COL_HIGH_CMD  = 8'h10;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_CHAR  = 2'd1;
    localparam logic [1:0] ACT_END   = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] page;
        logic [7:0] char_code;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic [7:0] repeat_count;
        logic       last;
    } result_t;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_CHAR,
        CMD_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [2:0] page;
        logic [5:0] glyph;
        logic [7:0] rest;
    } cmd_t;

    localparam logic [7:0] FONT_ROM [0:GLYPH_COUNT-1][0:GLYPH_WIDTH-1] = '{
        '{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h08,8'h08,8'h3E,8'h08,8'h08},
        '{8'h08,8'h08,8'h08,8'h08,8'h08}, '{8'h00,8'h60,8'h60,8'h00,8'h00},
        '{8'h00,8'h36,8'h36,8'h00,8'h00},
        '{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h42,8'h7F,8'h40,8'h00},
        '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4B,8'h31},
        '{8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
        '{8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
        '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
        '{8'h7E,8'h11,8'h11,8'h11,8'h7E}, '{8'h7F,8'h49,8'h49,8'h49,8'h36},
        '{8'h3E,8'h41,8'h41,8'h41,8'h22}, '{8'h7F,8'h41,8'h41,8'h22,8'h1C},
        '{8'h7F,8'h49,8'h49,8'h49,8'h41}, '{8'h7F,8'h09,8'h09,8'h09,8'h01},
        '{8'h3E,8'h41,8'h49,8'h49,8'h7A}, '{8'h7F,8'h08,8'h08,8'h08,8'h7F},
        '{8'h00,8'h41,8'h7F,8'h41,8'h00}, '{8'h20,8'h40,8'h41,8'h3F,8'h01},
        '{8'h7F,8'h08,8'h14,8'h22,8'h41}, '{8'h7F,8'h40,8'h40,8'h40,8'h40},
        '{8'h7F,8'h02,8'h0C,8'h02,8'h7F}, '{8'h7F,8'h04,8'h08,8'h10,8'h7F},
        '{8'h3E,8'h41,8'h41,8'h41,8'h3E}, '{8'h7F,8'h09,8'h09,8'h09,8'h06},
        '{8'h3E,8'h41,8'h51,8'h21,8'h5E}, '{8'h7F,8'h09,8'h19,8'h29,8'h46},
        '{8'h46,8'h49,8'h49,8'h49,8'h31}, '{8'h01,8'h01,8'h7F,8'h01,8'h01},
        '{8'h3F,8'h40,8'h40,8'h40,8'h3F}, '{8'h1F,8'h20,8'h40,8'h20,8'h1F},
        '{8'h3F,8'h40,8'h38,8'h40,8'h3F}, '{8'h63,8'h14,8'h08,8'h14,8'h63},
        '{8'h07,8'h08,8'h70,8'h08,8'h07}, '{8'h61,8'h51,8'h49,8'h45,8'h43}
    };

    // Character code to glyph slot; anything outside the set maps to blank.
    function automatic logic [5:0] font_index(input logic [7:0] code);
        logic [5:0] idx;
        idx = 6'd0;
        if (code == 8'h2B)
            idx = 6'd1;
        else if (code == 8'h2D)
            idx = 6'd2;
        else if (code == 8'h2E)
            idx = 6'd3;
        else if (code == 8'h3A)
            idx = 6'd4;
        else if (code >= 8'h30 && code <= 8'h39)
            idx = 6'(code - 8'h30) + 6'd5;
        else if (code >= 8'h41 && code <= 8'h5A)
            idx = 6'(code - 8'h41) + 6'd15;
        return idx;
    endfunction

    function automatic logic [7:0] font_column_byte(input logic [5:0] glyph,
                                                    input logic [2:0] col);
        logic [7:0] b;
        b = 8'h00;
        if (int'(glyph) < GLYPH_COUNT && int'(col) < GLYPH_WIDTH)
            b = FONT_ROM[glyph][col];
        return b;
    endfunction

endpackage

// File: rtl/tlgr_front.sv
// Front end: accepts items, keeps the column position, queues commands.
module tlgr_front (
    input  logic             clk,
    input  logic             rst_n,
    input  tlgr_pkg::item_t  item,
    input  logic             push,
    output logic             full,
    output tlgr_pkg::cmd_t   cmd,
    output logic             cmd_push,
    input  logic             cmd_full
);

    logic [7:0] column_pos_reg;
    logic [7:0] column_pos_next;
    logic       accept;

    assign accept = push && !cmd_full;
    assign full   = cmd_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            column_pos_reg <= 8'd0;
        else
            column_pos_reg <= column_pos_next;
    end

    always_comb
    begin
        column_pos_next = column_pos_reg;
        cmd_push        = 1'b0;
        cmd.kind        = tlgr_pkg::CMD_START;
        cmd.page        = item.page;
        cmd.glyph       = tlgr_pkg::font_index(item.char_code);
        cmd.rest        = 8'(tlgr_pkg::LINE_COLUMNS) - column_pos_reg;
        unique case (item.action)
            tlgr_pkg::ACT_START:
            begin
                cmd.kind = tlgr_pkg::CMD_START;
                if (accept)
                begin
                    cmd_push        = 1'b1;
                    column_pos_next = 8'd0;
                end
            end
            tlgr_pkg::ACT_CHAR:
            begin
                cmd.kind = tlgr_pkg::CMD_CHAR;
                // characters past the last full cell are dropped
                if (accept && column_pos_reg <= 8'(tlgr_pkg::LAST_FIT))
                begin
                    cmd_push        = 1'b1;
                    column_pos_next = column_pos_reg + 8'(tlgr_pkg::CELL_WIDTH);
                end
            end
            tlgr_pkg::ACT_END:
            begin
                cmd.kind = tlgr_pkg::CMD_END;
                if (accept && column_pos_reg < 8'(tlgr_pkg::LINE_COLUMNS))
                begin
                    cmd_push        = 1'b1;
                    column_pos_next = 8'(tlgr_pkg::LINE_COLUMNS);
                end
            end
            default:
            begin
                cmd.kind = tlgr_pkg::CMD_START;
            end
        endcase
    end

endmodule

// File: rtl/tlgr_queue.sv
// Short command queue between front and back ends.
module tlgr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  tlgr_pkg::cmd_t  din,
    input  logic            push,
    output logic            full,
    output tlgr_pkg::cmd_t  dout,
    input  logic            pop,
    output logic            empty
);

    localparam int PW = $clog2(tlgr_pkg::QUEUE_DEPTH);

    tlgr_pkg::cmd_t mem [tlgr_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW:0]    count_reg;
    logic           do_push;
    logic           do_pop;

    assign full    = count_reg == (PW+1)'(tlgr_pkg::QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: rtl/tlgr_back.sv
// Back end: steps through each queued command and emits its result bytes.
module tlgr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  tlgr_pkg::cmd_t     cmd,
    input  logic               cmd_empty,
    output logic               cmd_pop,
    output tlgr_pkg::result_t  result,
    output logic               empty,
    input  logic               pop
);

    logic [2:0]         step_reg;
    logic [2:0]         step_next;
    logic               out_valid_reg;
    tlgr_pkg::result_t  out_reg;
    tlgr_pkg::result_t  res;
    logic               load;
    logic               final_step;

    assign load    = !cmd_empty && (!out_valid_reg || pop);
    assign cmd_pop = load && final_step;
    assign result  = out_reg;
    assign empty   = !out_valid_reg;

    always_comb
    begin
        res.out_byte     = 8'h00;
        res.is_data      = 1'b1;
        res.repeat_count = 8'd1;
        res.last         = 1'b0;
        final_step       = 1'b0;
        unique case (cmd.kind)
            tlgr_pkg::CMD_START:
            begin
                res.is_data = 1'b0;
                if (step_reg == 3'd0)
                    res.out_byte = tlgr_pkg::PAGE_CMD_BASE + {5'd0, cmd.page};
                else if (step_reg == 3'd1)
                    res.out_byte = tlgr_pkg::COL_LOW_CMD;
                else
                begin
                    res.out_byte = tlgr_pkg::COL_HIGH_CMD;
                    final_step   = 1'b1;
                end
            end
            tlgr_pkg::CMD_CHAR:
            begin
                // five glyph columns, then the blank spacer
                if (step_reg == 3'(tlgr_pkg::GLYPH_WIDTH))
                    final_step = 1'b1;
                else
                    res.out_byte = tlgr_pkg::font_column_byte(cmd.glyph, step_reg);
            end
            tlgr_pkg::CMD_END:
            begin
                res.repeat_count = cmd.rest;
                final_step       = 1'b1;
            end
            default:
            begin
                final_step = 1'b1;
            end
        endcase
        res.last  = final_step;
        step_next = final_step ? 3'd0 : step_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                step_reg      <= step_next;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= res;
    end

endmodule

// File: rtl/text_line_glyph_renderer.sv
// Top level of the text line glyph renderer: front end, command queue, back end.
// Path: with the back end idle, an accepted request passes through its queue entry and then the output register.
// Throughput: one result byte per cycle from the back end while commands are queued and the receiver
//   pops; a character request gives six bytes, a start three and an end one.
// Requests enter while earlier ones are still draining through the queue.
// Reset: asynchronous, active low; clears column position, queue and output.
module text_line_glyph_renderer (
    input  logic               clk,
    input  logic               rst_n,
    input  tlgr_pkg::item_t    item,
    input  logic               push,
    output logic               full,
    output tlgr_pkg::result_t  result,
    output logic               empty,
    input  logic               pop
);

    // Command handed from the front end to the queue.
    tlgr_pkg::cmd_t  front_cmd;
    logic            front_push;
    logic            q_full;

    // Queue head seen by the back end.
    tlgr_pkg::cmd_t  head_cmd;
    logic            q_empty;
    logic            q_pop;

    // Front: decides whether a request produces anything and tracks the column.
    tlgr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .push     (push),
        .full     (full),
        .cmd      (front_cmd),
        .cmd_push (front_push),
        .cmd_full (q_full)
    );

    // Queue: decouples request intake from byte output.
    tlgr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (front_cmd),
        .push  (front_push),
        .full  (q_full),
        .dout  (head_cmd),
        .pop   (q_pop),
        .empty (q_empty)
    );

    // Back: expands each command into result bytes through an output register.
    tlgr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_empty (q_empty),
        .cmd_pop   (q_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

// File: verif/glyph_stream_checker.sv
// Checker for the glyph renderer: predicts the display byte stream and compares it.
module glyph_stream_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  tlgr_pkg::item_t    item,
    input  logic               push,
    input  logic               full,
    input  tlgr_pkg::result_t  result,
    input  logic               empty,
    input  logic               pop,
    output int                 fail_count,
    output int                 pending,
    output int                 n_requests,
    output int                 n_results,
    output int                 n_clipped
);
    timeunit 1ns;
    timeprecision 1ps;

    import tlgr_pkg::*;

    // Characters in font order; anything not found draws as the blank glyph.
    localparam logic [8*41-1:0] GLYPH_SET = " +-.:0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

    // Five columns per glyph, leftmost column in the top byte.
    localparam logic [39:0] GLYPH_BITMAPS [0:40] = '{
        40'h0000000000, 40'h08083E0808, 40'h0808080808, 40'h0060600000,
        40'h0036360000,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E,
        40'h7E1111117E, 40'h7F49494936, 40'h3E41414122, 40'h7F4141221C,
        40'h7F49494941, 40'h7F09090901, 40'h3E4149497A, 40'h7F0808087F,
        40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906,
        40'h3E4151215E, 40'h7F09192946, 40'h4649494931, 40'h01017F0101,
        40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
        40'h0708700807, 40'h6151494543
    };

    logic [7:0] line_column = 8'd0;
    result_t    display_stream_q[$];
    int         errors = 0;
    int         requests = 0;
    int         results_seen = 0;
    int         clipped = 0;

    function automatic int glyph_slot(input logic [7:0] code);
        int slot;
        slot = 0;
        for (int i = 0; i < 41; i++)
            if (GLYPH_SET[8*(40-i) +: 8] == code)
                slot = i;
        return slot;
    endfunction

    function automatic void queue_byte(input logic [7:0] b, input logic data,
                                       input logic [7:0] rep, input logic fin);
        result_t r;
        r.out_byte     = b;
        r.is_data      = data;
        r.repeat_count = rep;
        r.last         = fin;
        display_stream_q.push_back(r);
    endfunction

    function automatic void render_request(input item_t req);
        int g;
        g = 0;
        case (req.action)
            ACT_START:
            begin
                queue_byte(PAGE_CMD_BASE + 8'(req.page), 1'b0, 8'd1, 1'b0);
                queue_byte(COL_LOW_CMD, 1'b0, 8'd1, 1'b0);
                queue_byte(COL_HIGH_CMD, 1'b0, 8'd1, 1'b1);
                line_column = 8'd0;
            end
            ACT_CHAR:
            begin
                if (int'(line_column) > LAST_FIT)
                    clipped++;
                else
                begin
                    g = glyph_slot(req.char_code);
                    for (int c = 0; c < GLYPH_WIDTH; c++)
                        queue_byte(GLYPH_BITMAPS[g][39-8*c -: 8], 1'b1, 8'd1, 1'b0);
                    queue_byte(8'h00, 1'b1, 8'd1, 1'b1);
                    line_column = line_column + 8'(CELL_WIDTH);
                end
            end
            ACT_END:
            begin
                // pad to the right margin in one run; a full line gives nothing
                if (int'(line_column) < LINE_COLUMNS)
                begin
                    queue_byte(8'h00, 1'b1, 8'(LINE_COLUMNS - int'(line_column)), 1'b1);
                    line_column = 8'(LINE_COLUMNS);
                end
            end
            default:
            begin
            end
        endcase
        requests++;
    endfunction

    function automatic void check_result(input result_t got);
        result_t want;
        if (display_stream_q.size() == 0)
        begin
            $error("unexpected result: out_byte %h is_data %b repeat_count %0d last %b",
                   got.out_byte, got.is_data, got.repeat_count, got.last);
            errors++;
        end
        else
        begin
            want = display_stream_q.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.is_data !== want.is_data)
            begin
                $error("is_data: expected %b, got %b", want.is_data, got.is_data);
                errors++;
            end
            if (got.repeat_count !== want.repeat_count)
            begin
                $error("repeat_count: expected %0d, got %0d",
                       want.repeat_count, got.repeat_count);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %b, got %b", want.last, got.last);
                errors++;
            end
        end
        results_seen++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_column = 8'd0;
            display_stream_q.delete();
            pending <= 0;
        end
        else
        begin
            if (pop && !empty)
                check_result(result);
            if (push && !full)
                render_request(item);
            pending <= display_stream_q.size();
        end
        fail_count <= errors;
        n_requests <= requests;
        n_results  <= results_seen;
        n_clipped  <= clipped;
    end

endmodule

// File: verif/testbench.sv
// Top of the glyph renderer testbench: clock, reset, request stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tlgr_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;   // reserved action, block ignores it
    localparam int ITEMS      = 370;
    localparam int CALM_TAIL  = 50;             // last requests run with no idling
    localparam int LONG_HOLD  = 400;            // receiver hold-off, fills the queue
    localparam int STALL_CAP  = 1500;           // cycles with no handshake at all

    logic    clk;
    logic    rst_n;
    item_t   item;
    logic    push;
    logic    full;
    result_t result;
    logic    empty;
    logic    pop;

    int fail_count;
    int pending;
    int n_requests;
    int n_results;
    int n_clipped;

    int n_offered  = 0;     // requests sent, the reserved action apart
    int n_lines    = 0;
    bit quiet      = 1'b0;  // set for the tail: no idling on either side
    bit send_calm  = 1'b0;  // sender stretch without gaps
    bit long_hold_req = 1'b0;
    int idle_stall = 0;

    text_line_glyph_renderer uut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .push  (push),
        .full  (full),
        .result(result),
        .empty (empty),
        .pop   (pop)
    );

    glyph_stream_checker stream_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .push      (push),
        .full      (full),
        .result    (result),
        .empty     (empty),
        .pop       (pop),
        .fail_count(fail_count),
        .pending   (pending),
        .n_requests(n_requests),
        .n_results (n_results),
        .n_clipped (n_clipped)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Character codes biased towards the font, with a share of arbitrary bytes
    // so that every bit of the code toggles and unknown codes show up.
    function automatic logic [7:0] pick_code();
        logic [7:0] code;
        case ($urandom_range(0, 5))
            0: code = 8'h30 + 8'($urandom_range(0, 9));
            1, 2: code = 8'h41 + 8'($urandom_range(0, 25));
            3:
            begin
                case ($urandom_range(0, 4))
                    0: code = 8'h20;   // space
                    1: code = 8'h2B;   // plus
                    2: code = 8'h2D;   // minus
                    3: code = 8'h2E;   // full stop
                    default: code = 8'h3A;   // colon
                endcase
            end
            default: code = 8'($urandom_range(0, 255));
        endcase
        return code;
    endfunction

    // Offer one request, entered and left at a falling edge. A gap lowers push
    // first; with no gap push stays high straight into the next request.
    task automatic offer(input logic [1:0] act, input logic [2:0] pg, input logic [7:0] code);
        int gap;
        gap = 0;
        if (!quiet)
        begin
            if ($urandom_range(0, 31) == 0)
                send_calm = !send_calm;
            if (!send_calm && $urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 17);
        end
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item.action    <= act;
        item.page      <= pg;
        item.char_code <= code;
        push           <= 1'b1;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
        if (act != ACT_UNUSED)
            n_offered++;
        quiet = (n_offered >= ITEMS - CALM_TAIL);
    endtask

    // A line: page select, some characters and, when closed, padding to the margin.
    task automatic send_line(input int n_chars, input bit closed);
        offer(ACT_START, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        repeat (n_chars)
            offer(ACT_CHAR, 3'($urandom_range(0, 7)), pick_code());
        if (closed)
            offer(ACT_END, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        n_lines++;
    endtask

    // Receiver: pops with random hold-off bursts, calm stretches, and the one
    // long hold-off that the stimulus asks for to back the block up.
    initial
    begin
        int idle;
        bit calm;
        idle = 0;
        calm = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 63) == 0)
                calm = !calm;
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                idle = LONG_HOLD;
            end
            else if (idle == 0 && !quiet && !calm && $urandom_range(0, 7) == 0)
                idle = $urandom_range(1, 17);
            if (idle > 0)
            begin
                pop <= 1'b0;
                idle--;
            end
            else
                pop <= 1'b1;
        end
    end

    // Watchdog: a run of cycles with neither a request nor a result taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_stall <= 0;
            else if (idle_stall >= STALL_CAP)
            begin
                $display("[text_line_glyph_renderer] ERROR");
                $finish;
            end
            else
                idle_stall <= idle_stall + 1;
        end
    end

    initial
    begin
        logic [7:0] probe_codes [12];
        int r;
        probe_codes = '{8'h00, 8'hFF, 8'h20, 8'h2B, 8'h2D, 8'h2E, 8'h3A,
                        8'h30, 8'h39, 8'h41, 8'h5A, 8'h61};
        r = 0;
        rst_n = 1'b0;
        push  = 1'b0;
        pop   = 1'b0;
        item  = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: character and end before any page select (column from
        // reset), an empty line padded in full, both page extremes, every
        // punctuation mark, digit and letter bounds, code zero, 0xFF and a
        // lowercase letter drawn blank, the reserved action, a second end on a
        // full line and a character after it, both giving nothing.
        offer(ACT_CHAR, 3'd5, 8'h41);
        offer(ACT_END, 3'd2, 8'h00);
        offer(ACT_START, 3'd0, 8'hFF);
        offer(ACT_END, 3'd7, 8'h55);
        offer(ACT_START, 3'd7, 8'h00);
        foreach (probe_codes[i])
            offer(ACT_CHAR, 3'($urandom_range(0, 7)), probe_codes[i]);
        offer(ACT_UNUSED, 3'd7, 8'hFF);
        offer(ACT_END, 3'd0, 8'h00);
        offer(ACT_END, 3'd1, 8'h41);
        offer(ACT_CHAR, 3'd0, 8'h5A);

        // A line that runs past the margin: the last fitting cell lands at
        // column 120, later characters are clipped, the end pads two columns.
        // The receiver holds off meanwhile so the block fills and stalls.
        long_hold_req = 1'b1;
        send_line(23, 1'b1);

        // Random part: mostly whole lines, some clipped, plus noise.
        while (n_offered < ITEMS)
        begin
            r = $urandom_range(0, 19);
            if (r < 12)
                send_line($urandom_range(0, 12), 1'b1);
            else if (r < 16)
                send_line($urandom_range(13, 24), 1'b1);
            else if (r < 18)
                send_line($urandom_range(0, 8), 1'b0);   // line left open
            else
                repeat ($urandom_range(1, 4))
                    offer(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                          8'($urandom_range(0, 255)));
        end
        push <= 1'b0;

        // Drain, then wait on for anything stray behind the output register.
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d requests in %0d text lines, %0d result bytes checked,",
                 n_requests, n_lines, n_results);
        $display("with %0d characters clipped at the right margin.", n_clipped);
        if (fail_count == 0)
            $display("[text_line_glyph_renderer] OK");
        else
            $display("[text_line_glyph_renderer] ERROR");
        $finish;
    end

endmodule
